>>> rtl/lvtc_pkg.sv
package lvtc_pkg;

	localparam int SLOTS    = 16;
	localparam int TAG_BITS = 32;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int VID_W    = 32;
	localparam int SLOT_W   = 4;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_ALLOC  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_SELECT,
		ST_UPDATE
	} lvtc_state_t;

	typedef struct packed {
		logic capture;
		logic match;
		logic select;
		logic update;
	} lvtc_cmd_t;

	typedef struct packed {
		logic [SLOTS-1:0] mru_vec;
	} lvtc_status_t;

endpackage

>>> rtl/lvtc_req_if.sv
interface lvtc_req_if;
	import lvtc_pkg::*;

	logic             valid;
	logic             ready;
	logic             action;
	logic [VID_W-1:0] vertex_id;

	modport source (output valid, output action, output vertex_id, input ready);
	modport sink   (input valid, input action, input vertex_id, output ready);
endinterface

>>> rtl/lvtc_rsp_if.sv
interface lvtc_rsp_if;
	import lvtc_pkg::*;

	logic              valid;
	logic              ready;
	logic              hit;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, output hit, output slot, input ready);
	modport sink   (input valid, input hit, input slot, output ready);
endinterface

>>> rtl/lvtc_ctrl.sv
module lvtc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output lvtc_pkg::lvtc_cmd_t   cmd
);
	import lvtc_pkg::*;

	lvtc_state_t state_q, state_d;
	logic        rsp_valid_q;
	logic        out_free;

	// output register is free if empty or being drained this cycle
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_MATCH;
			end
			ST_MATCH:  state_d = ST_SELECT;
			ST_SELECT: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_MATCH:  cmd.match  = 1'b1;
			ST_SELECT: cmd.select = 1'b1;
			ST_UPDATE: cmd.update = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.update) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

>>> rtl/lvtc_dp.sv
module lvtc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lvtc_pkg::lvtc_cmd_t           cmd,
	input  logic                          req_action,
	input  logic [lvtc_pkg::VID_W-1:0]    req_vertex_id,
	output logic                          rsp_hit,
	output logic [lvtc_pkg::SLOT_W-1:0]   rsp_slot,
	output lvtc_pkg::lvtc_status_t        status
);
	import lvtc_pkg::*;

	logic [SLOTS-1:0]    valid_q;
	logic [TAG_BITS-1:0] tag_q  [SLOTS];
	logic [IDX_W-1:0]    rank_q [SLOTS];

	logic                act_q;
	logic [TAG_BITS-1:0] tag_in_q;
	logic [SLOTS-1:0]    match_q;
	logic [SLOTS-1:0]    lru_q;
	logic [IDX_W-1:0]    sel_idx_q;
	logic [IDX_W-1:0]    sel_rank_q;
	logic                sel_hit_q;
	logic                rsp_hit_q;
	logic [SLOT_W-1:0]   rsp_slot_q;

	logic [SLOTS-1:0]    rank_hit;
	logic [IDX_W-1:0]    min_rank;
	logic [IDX_W-1:0]    hit_idx;
	logic [IDX_W-1:0]    lru_idx;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= req_action;
			tag_in_q <= TAG_BITS'(req_vertex_id);
		end
	end

	// parallel tag compare, plus the least recent slot
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			for (int i = 0; i < SLOTS; i++) begin
				match_q[i] <= valid_q[i] && (tag_q[i] == tag_in_q);
				lru_q[i]   <= (rank_q[i] == IDX_W'(SLOTS - 1));
			end
		end
	end

	// lowest-rank match: fold matches into rank order, then pick lowest; also encode the least recent slot
	always_comb begin
		rank_hit = '0;
		for (int r = 0; r < SLOTS; r++) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (match_q[i] && (rank_q[i] == IDX_W'(r))) rank_hit[r] = 1'b1;
			end
		end
		min_rank = '0;
		for (int r = SLOTS - 1; r >= 0; r--) begin
			if (rank_hit[r]) min_rank = IDX_W'(r);
		end
		hit_idx = '0;
		lru_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match_q[i] && (rank_q[i] == min_rank)) hit_idx = hit_idx | IDX_W'(i);
			if (lru_q[i]) lru_idx = lru_idx | IDX_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_hit_q <= 1'b0;
		end else if (cmd.select) begin
			sel_hit_q <= (act_q == ACT_ALLOC) || (|rank_hit);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.select) begin
			if (act_q == ACT_ALLOC) begin
				sel_idx_q  <= lru_idx;
				sel_rank_q <= IDX_W'(SLOTS - 1);
			end else begin
				sel_idx_q  <= hit_idx;
				sel_rank_q <= min_rank;
			end
		end
	end

	// recency and valid update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < SLOTS; i++) rank_q[i] <= IDX_W'(i);
		end else if (cmd.update && sel_hit_q) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (IDX_W'(i) == sel_idx_q) begin
					rank_q[i] <= '0;
				end else if (rank_q[i] < sel_rank_q) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			if (act_q == ACT_ALLOC) valid_q[sel_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && (act_q == ACT_ALLOC)) begin
			tag_q[sel_idx_q] <= tag_in_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_hit_q  <= 1'b0;
			rsp_slot_q <= '0;
		end else if (cmd.update) begin
			rsp_hit_q  <= sel_hit_q;
			rsp_slot_q <= sel_hit_q ? SLOT_W'(sel_idx_q) : '0;
		end
	end

	assign rsp_hit  = rsp_hit_q;
	assign rsp_slot = rsp_slot_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) status.mru_vec[i] = (rank_q[i] == '0);
	end

endmodule

>>> rtl/lru_vertex_tag_cache_top.sv
// Fully associative LRU tag store for post-transform vertex indices, 16 slots
// by default. A lookup (action 0) compares vertex_id against every valid slot
// at once; on a hit it returns the slot and makes it most recent, on a miss it
// returns hit=0, slot=0 and changes nothing. If several slots carry the same
// tag the most recent one wins. An allocate (action 1) takes the least recent
// slot, stores the tag there, marks it valid and most recent, and returns it
// with hit=1; it never searches, so duplicates are possible. After reset every
// slot is invalid and the order runs from slot 0 (most recent) to the last
// slot (least recent). One transaction is handled at a time and runs these
// steps from acceptance to the next acceptance: capture, tag compare, rank
// select, recency update. The result appears the cycle after the update and
// sits in an output register, so the next request is accepted while it waits;
// the update step stalls only if the previous result has still not been taken.
module lru_vertex_tag_cache_top (
	input logic        clk,
	input logic        arst_n,
	lvtc_req_if.sink   req,
	lvtc_rsp_if.source rsp
);
	import lvtc_pkg::*;

	lvtc_cmd_t    cmd;      // step strobes, controller -> datapath
	lvtc_status_t status;   // recency view for checking

	// sequencer: handshakes and step order
	lvtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// tags, valid bits, ranks, compare and select logic, result register
	lvtc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_action    (req.action),
		.req_vertex_id (req.vertex_id),
		.rsp_hit       (rsp.hit),
		.rsp_slot      (rsp.slot),
		.status        (status)
	);

	// exactly one slot is most recent at all times
	a_mru_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(status.mru_vec))
		else $error("recency ranks lost their single most recent slot");

	// a miss always reports slot zero
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.slot == '0)
		else $error("miss reported a nonzero slot");

	// block is busy for the cycle after a transaction is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a transaction is in flight");

	// the rank update is only issued once the output register can take it
	a_update_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !rsp.valid || rsp.ready)
		else $error("result register overwritten before it was taken");

endmodule
